[hdl/nwk_pkg.sv]
// Shared types and codes for the tree-format token parser.
`default_nettype none
package nwk_pkg;

	// Token kinds; codes above KIND_COMMENT count as unknown.
	localparam logic [3:0] KIND_UNKNOWN  = 4'd0;
	localparam logic [3:0] KIND_OPEN     = 4'd1;
	localparam logic [3:0] KIND_CLOSE    = 4'd2;
	localparam logic [3:0] KIND_COMMA    = 4'd3;
	localparam logic [3:0] KIND_SEMI     = 4'd4;
	localparam logic [3:0] KIND_BARE     = 4'd5;
	localparam logic [3:0] KIND_QUOTED   = 4'd6;
	localparam logic [3:0] KIND_NUMBER   = 4'd7;
	localparam logic [3:0] KIND_TAG      = 4'd8;
	localparam logic [3:0] KIND_COMMENT  = 4'd9;
	localparam logic [3:0] KIND_NONE     = 4'd15;

	// Event codes.
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_LABEL      = 3'd1;
	localparam logic [2:0] EV_LENGTH     = 3'd2;
	localparam logic [2:0] EV_TAG        = 3'd3;
	localparam logic [2:0] EV_COMMENT    = 3'd4;
	localparam logic [2:0] EV_NODE_DONE  = 3'd5;
	localparam logic [2:0] EV_TREE_DONE  = 3'd6;
	localparam logic [2:0] EV_ERROR      = 3'd7;

	// Error codes.
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_INVALID    = 4'd1;
	localparam logic [3:0] ERR_REOPENED   = 4'd2;
	localparam logic [3:0] ERR_BAD_START  = 4'd3;
	localparam logic [3:0] ERR_BAD_COMMA  = 4'd4;
	localparam logic [3:0] ERR_EXTRA_CLOSE = 4'd5;
	localparam logic [3:0] ERR_BAD_CLOSE  = 4'd6;
	localparam logic [3:0] ERR_MISS_CLOSE = 4'd7;
	localparam logic [3:0] ERR_BAD_SEMI   = 4'd8;
	localparam logic [3:0] ERR_NO_SEMI    = 4'd9;
	localparam logic [3:0] ERR_OVERFLOW   = 4'd10;

	// Allowed predecessor kinds, one bit per kind code.
	localparam logic [15:0] PRED_OPEN   = 16'h020A;
	localparam logic [15:0] PRED_LABEL  = 16'h020E;
	localparam logic [15:0] PRED_NUMBER = 16'h026E;
	localparam logic [15:0] PRED_COMMA  = 16'h03EE;
	localparam logic [15:0] PRED_CLOSE  = 16'h03EC;
	localparam logic [15:0] PRED_SEMI   = 16'h03E4;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] token_handle;
		logic        end_of_input;
	} token_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  node_depth;
		logic        node_is_leaf;
		logic        label_unquoted;
		logic [15:0] value_handle;
		logic        tree_end;
		logic [3:0]  error_code;
	} event_t;

endpackage
`default_nettype wire

[hdl/newick_token_parser_top.sv]
// Tree-format token parser: one token beat in, one event beat out.
// A token goes from the input register through the checks into the event register.
// Throughput: one token per cycle; the input register and the event register advance
// together whenever the event register is empty or its beat is being taken.
// Reset clears the valid flags and returns the tree state to a fresh tree.
`default_nettype none
module newick_token_parser_top #(
	parameter int MAX_DEPTH = 255
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tok_valid,
	output logic                tok_stall,
	input  wire nwk_pkg::token_t tok,
	output logic                evt_valid,
	input  wire logic           evt_stall,
	output nwk_pkg::event_t     evt
);

	localparam logic [7:0] DepthLimit = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

	// Input register.
	logic            tok_valid_s1;
	nwk_pkg::token_t tok_s1;

	// Tree state.
	logic [7:0] depth_q;
	logic       closed_q;
	logic       first_q;
	logic [3:0] prev_q;
	logic [3:0] plain_q;
	logic       pend_q;
	logic [7:0] pdepth_q;
	logic       pleaf_q;

	logic [7:0] depth_d;
	logic       closed_d;
	logic       first_d;
	logic [3:0] prev_d;
	logic [3:0] plain_d;
	logic       pend_d;
	logic [7:0] pdepth_d;
	logic       pleaf_d;

	logic            advance;
	nwk_pkg::event_t result;
	nwk_pkg::event_t evt_q;
	logic            evt_valid_q;

	assign advance   = !evt_valid_q || !evt_stall;
	assign tok_stall = !advance;
	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	always_comb begin
		logic [3:0]  kind;
		logic [3:0]  err;
		logic [2:0]  ev;
		logic        unq;
		logic [15:0] vh;
		logic        tend;
		logic        done;
		logic        unknown;

		kind    = tok_s1.token_kind;
		err     = nwk_pkg::ERR_NONE;
		ev      = nwk_pkg::EV_NONE;
		unq     = 1'b0;
		vh      = '0;
		tend    = 1'b0;
		done    = 1'b0;
		unknown = (kind == nwk_pkg::KIND_UNKNOWN) || (kind > nwk_pkg::KIND_COMMENT);

		depth_d  = depth_q;
		closed_d = closed_q;
		first_d  = first_q;
		prev_d   = prev_q;
		plain_d  = plain_q;
		pend_d   = pend_q;
		pdepth_d = pdepth_q;
		pleaf_d  = pleaf_q;

		priority if (unknown) begin
			err = nwk_pkg::ERR_INVALID;
		end else if (kind == nwk_pkg::KIND_OPEN) begin
			priority if (prev_q != nwk_pkg::KIND_NONE && !nwk_pkg::PRED_OPEN[prev_q])
				err = nwk_pkg::ERR_INVALID;
			else if (closed_q)
				err = nwk_pkg::ERR_REOPENED;
			else if (depth_q >= DepthLimit)
				err = nwk_pkg::ERR_OVERFLOW;
			else
				depth_d = depth_q + 8'd1;
		end else if (first_q && kind != nwk_pkg::KIND_COMMENT) begin
			err = nwk_pkg::ERR_BAD_START;
		end else if (first_q) begin
			ev = nwk_pkg::EV_NONE;
		end else begin
			// A node opens on the first attachable token after a boundary.
			if (!pend_q) begin
				pend_d   = 1'b1;
				pdepth_d = depth_q;
				pleaf_d  = (plain_q == nwk_pkg::KIND_OPEN) || (plain_q == nwk_pkg::KIND_COMMA);
			end
			unique case (kind)
				nwk_pkg::KIND_BARE, nwk_pkg::KIND_QUOTED: begin
					if (!nwk_pkg::PRED_LABEL[prev_q]) begin
						err = nwk_pkg::ERR_INVALID;
					end else begin
						ev  = nwk_pkg::EV_LABEL;
						vh  = tok_s1.token_handle;
						unq = (kind == nwk_pkg::KIND_BARE);
					end
				end
				nwk_pkg::KIND_NUMBER: begin
					if (!nwk_pkg::PRED_NUMBER[prev_q]) begin
						err = nwk_pkg::ERR_INVALID;
					end else begin
						ev = nwk_pkg::EV_LENGTH;
						vh = tok_s1.token_handle;
					end
				end
				nwk_pkg::KIND_TAG: begin
					ev = nwk_pkg::EV_TAG;
					vh = tok_s1.token_handle;
				end
				nwk_pkg::KIND_COMMENT: begin
					ev = nwk_pkg::EV_COMMENT;
					vh = tok_s1.token_handle;
				end
				nwk_pkg::KIND_COMMA: begin
					if (!nwk_pkg::PRED_COMMA[prev_q]) begin
						err = nwk_pkg::ERR_BAD_COMMA;
					end else begin
						ev     = nwk_pkg::EV_NODE_DONE;
						pend_d = 1'b0;
					end
				end
				nwk_pkg::KIND_CLOSE: begin
					priority if (depth_q == 8'd0) begin
						err = nwk_pkg::ERR_EXTRA_CLOSE;
					end else if (!nwk_pkg::PRED_CLOSE[prev_q]) begin
						err = nwk_pkg::ERR_BAD_CLOSE;
					end else begin
						ev       = nwk_pkg::EV_NODE_DONE;
						pend_d   = 1'b0;
						depth_d  = depth_q - 8'd1;
						closed_d = (depth_q == 8'd1);
					end
				end
				default: begin
					// Semicolon.
					priority if (depth_q != 8'd0) begin
						err = nwk_pkg::ERR_MISS_CLOSE;
					end else if (!nwk_pkg::PRED_SEMI[prev_q]) begin
						err = nwk_pkg::ERR_BAD_SEMI;
					end else begin
						ev     = nwk_pkg::EV_NODE_DONE;
						tend   = 1'b1;
						done   = 1'b1;
						pend_d = 1'b0;
					end
				end
			endcase
		end

		if (err == nwk_pkg::ERR_NONE && tok_s1.end_of_input && !done)
			err = nwk_pkg::ERR_NO_SEMI;

		result = '0;
		if (err != nwk_pkg::ERR_NONE) begin
			result.event_res  = nwk_pkg::EV_ERROR;
			result.error_code = err;
		end else if (ev != nwk_pkg::EV_NONE) begin
			result.event_res      = ev;
			result.node_depth     = pdepth_d;
			result.node_is_leaf   = pleaf_d;
			result.label_unquoted = unq;
			result.value_handle   = vh;
			result.tree_end       = tend;
		end

		// Any error or a finished tree starts the next tree from scratch.
		if (err != nwk_pkg::ERR_NONE || done) begin
			depth_d  = '0;
			closed_d = 1'b0;
			first_d  = 1'b1;
			prev_d   = nwk_pkg::KIND_NONE;
			plain_d  = nwk_pkg::KIND_NONE;
			pend_d   = 1'b0;
			pdepth_d = '0;
			pleaf_d  = 1'b0;
		end else begin
			first_d = 1'b0;
			prev_d  = kind;
			if (kind != nwk_pkg::KIND_COMMENT)
				plain_d = kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
			evt_valid_q  <= 1'b0;
			depth_q      <= '0;
			closed_q     <= 1'b0;
			first_q      <= 1'b1;
			prev_q       <= nwk_pkg::KIND_NONE;
			plain_q      <= nwk_pkg::KIND_NONE;
			pend_q       <= 1'b0;
			pdepth_q     <= '0;
			pleaf_q      <= 1'b0;
		end else if (advance) begin
			tok_valid_s1 <= tok_valid;
			evt_valid_q  <= tok_valid_s1;
			if (tok_valid_s1) begin
				depth_q  <= depth_d;
				closed_q <= closed_d;
				first_q  <= first_d;
				prev_q   <= prev_d;
				plain_q  <= plain_d;
				pend_q   <= pend_d;
				pdepth_q <= pdepth_d;
				pleaf_q  <= pleaf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (tok_valid)
				tok_s1 <= tok;
			if (tok_valid_s1)
				evt_q <= result;
		end
	end

	// An error beat carries nothing but a nonzero error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.event_res == nwk_pkg::EV_ERROR |->
			evt.error_code != nwk_pkg::ERR_NONE && evt.node_depth == 8'd0 &&
			evt.value_handle == 16'd0 && !evt.tree_end && !evt.node_is_leaf)
		else $error("error event carries payload");

	// Nesting never passes the configured limit.
	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= DepthLimit)
		else $error("nesting depth above limit");

	// A closed tree has no open bracket.
	assert property (@(posedge clk) disable iff (!arst_n) closed_q |-> depth_q == 8'd0)
		else $error("tree closed with open brackets");

	// At the start of a tree nothing is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> depth_q == 8'd0 && !pend_q && !closed_q)
		else $error("fresh tree has leftover state");

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the tree-format token parser: directed and random token streams.
module testbench;
	import nwk_pkg::*;

	localparam int TREE_MAX_DEPTH = 255;
	localparam int DEPTH_LIMIT    = (TREE_MAX_DEPTH > 255) ? 255 : TREE_MAX_DEPTH;
	localparam int PLAN_SIZE      = 1100;
	localparam int TAIL_ITEMS     = 120;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 500000;

	typedef struct packed {
		token_t tok;
		logic   drain;
	} plan_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    tok_valid = 1'b0;
	logic    tok_stall;
	token_t  tok = '0;
	logic    evt_valid;
	logic    evt_stall = 1'b0;
	event_t  evt;

	plan_t   token_plan[$];
	token_t  tree_buf[$];
	event_t  expected_events[$];

	// Parser state as the predictor sees it.
	logic [7:0] tr_depth;
	logic       tr_closed;
	logic       tr_first;
	logic [3:0] tr_prev;
	logic [3:0] tr_last_plain;
	logic       tr_open_node;
	logic [7:0] tr_node_depth;
	logic       tr_node_leaf;

	int      tokens_sent = 0;
	int      planned_total = 0;
	int      events_seen = 0;
	int      trees_done = 0;
	int      error_events = 0;
	int      deepest = 0;
	int      mismatches = 0;
	int      cycle_count = 0;
	int      gap_left = 0;
	int      stall_left = 0;
	int      hold_left = 0;
	bit      hold_done = 1'b0;
	logic    hold_active = 1'b0;
	logic    quiet = 1'b0;

	newick_token_parser_top #(.MAX_DEPTH(TREE_MAX_DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic void fresh_tree();
		tr_depth      = '0;
		tr_closed     = 1'b0;
		tr_first      = 1'b1;
		tr_prev       = KIND_NONE;
		tr_last_plain = KIND_NONE;
		tr_open_node  = 1'b0;
		tr_node_depth = '0;
		tr_node_leaf  = 1'b0;
	endfunction

	function automatic event_t parse_token(input token_t t);
		event_t      r;
		logic [3:0]  k;
		logic [3:0]  prev;
		logic [3:0]  err;
		logic [2:0]  ev;
		logic [15:0] vh;
		logic        unq;
		logic        tend;
		logic        done;
		k = t.token_kind;
		prev = tr_prev;
		err = ERR_NONE;
		ev = EV_NONE;
		vh = '0;
		unq = 1'b0;
		tend = 1'b0;
		done = 1'b0;
		r = '0;
		if (k == KIND_UNKNOWN || k > KIND_COMMENT) begin
			err = ERR_INVALID;
		end else if (k == KIND_OPEN) begin
			if (prev != KIND_NONE && !PRED_OPEN[prev])
				err = ERR_INVALID;
			else if (tr_closed)
				err = ERR_REOPENED;
			else if (tr_depth >= DEPTH_LIMIT)
				err = ERR_OVERFLOW;
			else
				tr_depth = tr_depth + 8'd1;
		end else if (tr_first) begin
			// Only a comment may stand before the first bracket of a tree.
			if (k != KIND_COMMENT)
				err = ERR_BAD_START;
		end else begin
			if (!tr_open_node) begin
				tr_open_node  = 1'b1;
				tr_node_depth = tr_depth;
				tr_node_leaf  = (tr_last_plain == KIND_OPEN || tr_last_plain == KIND_COMMA);
			end
			case (k)
				KIND_BARE, KIND_QUOTED: begin
					if (!PRED_LABEL[prev]) begin
						err = ERR_INVALID;
					end else begin
						ev = EV_LABEL;
						vh = t.token_handle;
						unq = (k == KIND_BARE);
					end
				end
				KIND_NUMBER: begin
					if (!PRED_NUMBER[prev]) begin
						err = ERR_INVALID;
					end else begin
						ev = EV_LENGTH;
						vh = t.token_handle;
					end
				end
				KIND_TAG: begin
					ev = EV_TAG;
					vh = t.token_handle;
				end
				KIND_COMMENT: begin
					ev = EV_COMMENT;
					vh = t.token_handle;
				end
				KIND_COMMA: begin
					if (!PRED_COMMA[prev]) begin
						err = ERR_BAD_COMMA;
					end else begin
						ev = EV_NODE_DONE;
						tr_open_node = 1'b0;
					end
				end
				KIND_CLOSE: begin
					if (tr_depth == 0) begin
						err = ERR_EXTRA_CLOSE;
					end else if (!PRED_CLOSE[prev]) begin
						err = ERR_BAD_CLOSE;
					end else begin
						ev = EV_NODE_DONE;
						tr_open_node = 1'b0;
						tr_depth = tr_depth - 8'd1;
						if (tr_depth == 0)
							tr_closed = 1'b1;
					end
				end
				default: begin
					if (tr_depth != 0) begin
						err = ERR_MISS_CLOSE;
					end else if (!PRED_SEMI[prev]) begin
						err = ERR_BAD_SEMI;
					end else begin
						ev = EV_NODE_DONE;
						tend = 1'b1;
						done = 1'b1;
						tr_open_node = 1'b0;
					end
				end
			endcase
		end
		if (err == ERR_NONE && t.end_of_input && !done)
			err = ERR_NO_SEMI;
		if (err != ERR_NONE) begin
			r.event_res = EV_ERROR;
			r.error_code = err;
			fresh_tree();
		end else begin
			if (ev != EV_NONE) begin
				r.event_res      = ev;
				r.node_depth     = tr_node_depth;
				r.node_is_leaf   = tr_node_leaf;
				r.label_unquoted = unq;
				r.value_handle   = vh;
				r.tree_end       = tend;
			end
			if (done) begin
				fresh_tree();
			end else begin
				tr_first = 1'b0;
				tr_prev = k;
				if (k != KIND_COMMENT)
					tr_last_plain = k;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_handle();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic tok_add(input logic [3:0] kind, input logic [15:0] handle, input logic eoi);
		tree_buf.insert(tree_buf.size(),
			token_t'{token_kind: kind, token_handle: handle, end_of_input: eoi});
	endtask

	task automatic commit_tree(input bit mutate, input bit drain);
		int idx;
		if (mutate && tree_buf.size() > 0) begin
			idx = $urandom_range(0, tree_buf.size() - 1);
			case ($urandom_range(0, 2))
				0: tree_buf[idx].token_kind = 4'($urandom_range(0, 15));
				1: tree_buf[idx].end_of_input = 1'b1;
				default: tree_buf.delete(idx);
			endcase
		end
		foreach (tree_buf[i])
			token_plan.insert(token_plan.size(), plan_t'{tree_buf[i], drain && i == 0});
		tree_buf.delete();
	endtask

	// Comments, label, length and tag of one node, in the order the grammar allows.
	task automatic add_props(input bit need);
		bit any;
		any = 1'b0;
		if ($urandom_range(0, 4) == 0)
			tok_add(KIND_COMMENT, rand_handle(), 1'b0);
		if ($urandom_range(0, 1)) begin
			tok_add($urandom_range(0, 1) ? KIND_BARE : KIND_QUOTED, rand_handle(), 1'b0);
			any = 1'b1;
		end
		if ($urandom_range(0, 5) == 0)
			tok_add(KIND_COMMENT, rand_handle(), 1'b0);
		if ($urandom_range(0, 1)) begin
			tok_add(KIND_NUMBER, rand_handle(), 1'b0);
			any = 1'b1;
		end
		if ($urandom_range(0, 3) == 0) begin
			tok_add(KIND_TAG, rand_handle(), 1'b0);
			any = 1'b1;
		end
		if ($urandom_range(0, 5) == 0) begin
			tok_add(KIND_COMMENT, rand_handle(), 1'b0);
			any = 1'b1;
		end
		if (need && !any)
			tok_add(KIND_BARE, rand_handle(), 1'b0);
	endtask

	task automatic add_inner(input int room);
		int kids;
		kids = $urandom_range(1, 3);
		tok_add(KIND_OPEN, rand_handle(), 1'b0);
		for (int i = 0; i < kids; i++) begin
			if (i != 0)
				tok_add(KIND_COMMA, rand_handle(), 1'b0);
			// A lone child may not be empty, since "()" is rejected.
			if (room > 0 && $urandom_range(0, 2) == 0)
				add_inner(room - 1);
			else
				add_props(kids == 1);
		end
		tok_add(KIND_CLOSE, rand_handle(), 1'b0);
		add_props(1'b0);
	endtask

	// Token driver.
	always @(posedge clk) begin
		plan_t nxt;
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				expected_events.insert(expected_events.size(), parse_token(tok));
				tokens_sent++;
			end
			if (!tok_valid || !tok_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					tok_valid <= 1'b0;
				end else if (token_plan.size() == 0) begin
					tok_valid <= 1'b0;
				end else if (token_plan[0].drain && expected_events.size() != 0) begin
					tok_valid <= 1'b0;
				end else if (!quiet && !hold_active && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 9);
					tok_valid <= 1'b0;
				end else begin
					nxt = token_plan.pop_front();
					tok <= nxt.tok;
					tok_valid <= 1'b1;
				end
			end
			quiet <= (token_plan.size() < TAIL_ITEMS);
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Event monitor and receiver stall.
	always @(posedge clk) begin
		event_t want;
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				events_seen++;
				if (evt.tree_end === 1'b1)
					trees_done++;
				if (evt.event_res === EV_ERROR)
					error_events++;
				if (int'(evt.node_depth) > deepest)
					deepest = int'(evt.node_depth);
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected event beat: expected none, actual %p", $time, evt);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", 16'(want.event_res), 16'(evt.event_res));
					check_field("node_depth", 16'(want.node_depth), 16'(evt.node_depth));
					check_field("node_is_leaf", 16'(want.node_is_leaf),
						16'(evt.node_is_leaf));
					check_field("label_unquoted", 16'(want.label_unquoted),
						16'(evt.label_unquoted));
					check_field("value_handle", want.value_handle, evt.value_handle);
					check_field("tree_end", 16'(want.tree_end), 16'(evt.tree_end));
					check_field("error_code", 16'(want.error_code), 16'(evt.error_code));
				end
			end
			if (!hold_done && events_seen >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				evt_stall <= 1'b1;
				hold_active <= 1'b1;
			end else begin
				hold_active <= 1'b0;
				if (stall_left > 0) begin
					stall_left--;
					evt_stall <= 1'b1;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(0, 9);
					evt_stall <= 1'b1;
				end else begin
					evt_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d events outstanding", $time, expected_events.size());
		$display("** newick_token_parser_top: FAILED **");
		$finish;
	end

	initial begin
		int  pick;
		int  d;
		bit  drain_next;
		bit  drain_mid;
		bit  deep_label_done;
		bit  overflow_done;
		drain_next = 1'b1;
		drain_mid = 1'b0;
		deep_label_done = 1'b0;
		overflow_done = 1'b0;
		fresh_tree();

		// A full tree touching every valid token kind, closed by a final semicolon.
		tok_add(KIND_OPEN, 16'h0000, 1'b0);
		tok_add(KIND_BARE, 16'hFFFF, 1'b0);
		tok_add(KIND_NUMBER, 16'h0001, 1'b0);
		tok_add(KIND_TAG, 16'h8000, 1'b0);
		tok_add(KIND_COMMENT, 16'h7FFF, 1'b0);
		tok_add(KIND_COMMA, 16'h1234, 1'b0);
		tok_add(KIND_QUOTED, 16'h5555, 1'b0);
		tok_add(KIND_CLOSE, 16'h00FF, 1'b0);
		tok_add(KIND_NUMBER, 16'hAAAA, 1'b0);
		tok_add(KIND_SEMI, 16'hFF00, 1'b1);
		// Unknown kinds and a label where a tree has to start.
		tok_add(KIND_UNKNOWN, 16'h0000, 1'b0);
		tok_add(4'd15, 16'hFFFF, 1'b1);
		tok_add(KIND_BARE, 16'h0042, 1'b0);
		// A leading comment lets a bare leaf stand as the whole tree.
		tok_add(KIND_COMMENT, 16'h0101, 1'b0);
		tok_add(KIND_BARE, 16'h0202, 1'b0);
		tok_add(KIND_SEMI, 16'h0303, 1'b0);
		// Empty brackets, then a close at depth zero.
		tok_add(KIND_OPEN, 16'h0001, 1'b0);
		tok_add(KIND_CLOSE, 16'h0002, 1'b0);
		tok_add(KIND_COMMENT, 16'h0003, 1'b0);
		tok_add(KIND_CLOSE, 16'h0004, 1'b0);
		// Semicolon inside brackets.
		tok_add(KIND_OPEN, 16'h0005, 1'b0);
		tok_add(KIND_BARE, 16'h0006, 1'b0);
		tok_add(KIND_SEMI, 16'h0007, 1'b0);
		// Opening again after the outer bracket has closed.
		tok_add(KIND_OPEN, 16'h0008, 1'b0);
		tok_add(KIND_BARE, 16'h0009, 1'b0);
		tok_add(KIND_CLOSE, 16'h000A, 1'b0);
		tok_add(KIND_COMMENT, 16'h000B, 1'b0);
		tok_add(KIND_OPEN, 16'h000C, 1'b0);
		// Semicolon right after a comma, then input ending without a semicolon.
		tok_add(KIND_OPEN, 16'h000D, 1'b0);
		tok_add(KIND_BARE, 16'h000E, 1'b0);
		tok_add(KIND_CLOSE, 16'h000F, 1'b0);
		tok_add(KIND_COMMA, 16'h0010, 1'b0);
		tok_add(KIND_SEMI, 16'h0011, 1'b0);
		tok_add(KIND_OPEN, 16'h0012, 1'b1);
		commit_tree(1'b0, 1'b0);

		while (token_plan.size() < PLAN_SIZE) begin
			if (!deep_label_done && token_plan.size() >= 400) begin
				// Deep nesting so the upper bits of the node depth are exercised.
				d = $urandom_range(128, DEPTH_LIMIT);
				for (int i = 0; i < d; i++)
					tok_add(KIND_OPEN, rand_handle(), 1'b0);
				tok_add(KIND_BARE, rand_handle(), 1'b0);
				tok_add(KIND_CLOSE, rand_handle(), 1'b0);
				tok_add(KIND_COMMENT, rand_handle(), 1'b1);
				commit_tree(1'b0, 1'b0);
				deep_label_done = 1'b1;
			end else if (!overflow_done && token_plan.size() >= 750) begin
				for (int i = 0; i <= DEPTH_LIMIT; i++)
					tok_add(KIND_OPEN, rand_handle(), 1'b0);
				commit_tree(1'b0, 1'b0);
				overflow_done = 1'b1;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					repeat ($urandom_range(1, 4))
						tok_add(4'($urandom_range(0, 15)), rand_handle(),
							$urandom_range(0, 7) == 0);
					commit_tree(1'b0, 1'b0);
				end else begin
					if ($urandom_range(0, 7) == 0) begin
						tok_add(KIND_COMMENT, rand_handle(), 1'b0);
						add_props(1'b1);
					end else begin
						if ($urandom_range(0, 3) == 0)
							tok_add(KIND_COMMENT, rand_handle(), 1'b0);
						add_inner($urandom_range(0, 3));
					end
					tok_add(KIND_SEMI, rand_handle(), $urandom_range(0, 3) == 0);
					commit_tree(pick <= 2 && !drain_next, drain_next);
					drain_next = 1'b0;
				end
				if (!drain_mid && token_plan.size() >= 600) begin
					drain_next = 1'b1;
					drain_mid = 1'b1;
				end
			end
		end
		planned_total = token_plan.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (tokens_sent != planned_total || expected_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d tokens and checked %0d events in %0d cycles.",
			tokens_sent, events_seen, cycle_count);
		$display("Trees completed: %0d, error events: %0d, deepest node: %0d, mismatches: %0d.",
			trees_done, error_events, deepest, mismatches);
		if (mismatches == 0)
			$display("** newick_token_parser_top: PASSED **");
		else
			$display("** newick_token_parser_top: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hdl/nwk_pkg.sv
hdl/newick_token_parser_top.sv
tb/testbench.sv
